// File: hw/rtl/wts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants for the wake-time task scheduler.
// ----------------------------------------------------------------------------
package wts_pkg;

    localparam int ID_W      = 4;
    localparam int TIME_W    = 32;
    localparam int TPM_W     = 16;
    localparam int MARGIN_W  = 8;
    localparam int OP_W      = 2;
    localparam int MODE_W    = 2;
    localparam int OUT_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [TPM_W-1:0]    TPM_RESET    = 16'd1000;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd4;

    // offsets below this count as a wrapped timestamp
    localparam logic signed [TIME_W-1:0] WRAP_LIMIT = -32'sd16777215;

    localparam logic [CFG_IDX_W-1:0] CFG_TPM    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_QUEUE  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_RUN    = 2'd2,
        OP_NONE   = 2'd3
    } wts_op_t;

    typedef enum logic [OUT_W-1:0] {
        OUT_DONE     = 2'd0,
        OUT_DISPATCH = 2'd1,
        OUT_BUSY     = 2'd2,
        OUT_SLEEP    = 2'd3
    } wts_outcome_t;

    typedef enum logic [2:0] {
        Q_NOP,
        Q_APPEND,
        Q_INSERT,
        Q_DROP,
        Q_REMOVE
    } wts_q_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CANCEL,
        ST_SET,
        ST_INS_RD,
        ST_INS_CMP,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_MSEC_RD,
        ST_MSEC_CMP,
        ST_RUN_END,
        ST_DONE
    } wts_state_t;

    typedef struct packed {
        logic latch_in;
        logic cancel;
        logic set_wake;
        logic ins_rd;
        logic ins_step;
        logic ins_do;
        logic tick_rd;
        logic tick_cmp;
        logic tick_pop;
        logic msec_rd;
        logic msec_pop;
        logic run_end;
        logic load_out;
    } wts_cmd_t;

    typedef struct packed {
        logic is_queue;
        logic is_cancel;
        logic is_run;
        logic booked;
        logic ofs_pos;
        logic ins_end;
        logic ins_later;
        logic tick_empty;
        logic tick_due;
        logic msec_empty;
        logic msec_due;
    } wts_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/wts_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wts_req_if
// Request channel: one word per scheduler request.
// ----------------------------------------------------------------------------
interface wts_req_if;
    logic                         valid;
    logic                         ready;
    logic [wts_pkg::OP_W-1:0]     opcode;
    logic [wts_pkg::ID_W-1:0]     task_id;
    logic [wts_pkg::MODE_W-1:0]   wake_mode;
    logic [wts_pkg::TIME_W-1:0]   wake_value;
    logic [wts_pkg::TIME_W-1:0]   now_ticks;
    logic [wts_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, opcode, task_id, wake_mode, wake_value, now_ticks,
                    now_ms, input ready);
    modport sink   (input valid, opcode, task_id, wake_mode, wake_value, now_ticks,
                    now_ms, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wts_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wts_rsp_if
// Response channel: one word per completed request.
// ----------------------------------------------------------------------------
interface wts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [wts_pkg::OUT_W-1:0]   outcome;
    logic [wts_pkg::ID_W-1:0]    dispatched_task;
    logic                        went_ready;
    logic                        wrap_error;

    modport source (output valid, outcome, dispatched_task, went_ready, wrap_error,
                    input ready);
    modport sink   (input valid, outcome, dispatched_task, went_ready, wrap_error,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wts_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wts_pkg::CFG_IDX_W-1:0]   index;
    logic [wts_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wake_time_task_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wake_time_task_scheduler_core
// Task scheduler with tick and millisecond wake queues and a ready FIFO.
// ----------------------------------------------------------------------------
// Sequence (accept to result valid): an unused op is decoded and finished; a cancel
//   also clears the task; a queue cancels a booked task, then sets its wake time and
//   either goes straight to ready or does a sorted insert, reading and comparing
//   each entry passed; a run reads and compares each queue head, then ends.
// Throughput: one request at a time, next word taken in the cycle after the result
//   loads; each wake-time lookup uses the single read port of the wake-time memory.
// Reset: queues empty, no task booked, ticks_per_msec 1000, margin 4.
// ----------------------------------------------------------------------------
module wake_time_task_scheduler_core #(
    parameter int TASKS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wts_req_if.sink    req,
    wts_rsp_if.source  rsp,
    wts_cfg_if.sink    cfg
);
    import wts_pkg::*;

    wts_cmd_t    cmd;
    wts_status_t status;

    // config is always taken; the host is to write only while idle, which the block does not enforce
    assign cfg.ready = 1'b1;

    // sequencer: one request in flight, result held in the output register
    // so the next request can be taken while the previous word waits
    wts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: wake-time memory, booked flags, tick/msec/ready queues
    wts_datapath #(.TASKS(TASKS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .opcode          (req.opcode),
        .task_id         (req.task_id),
        .wake_mode       (req.wake_mode),
        .wake_value      (req.wake_value),
        .now_ticks       (req.now_ticks),
        .now_ms          (req.now_ms),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .outcome         (rsp.outcome),
        .dispatched_task (rsp.dispatched_task),
        .went_ready      (rsp.went_ready),
        .wrap_error      (rsp.wrap_error)
    );

endmodule
`default_nettype wire

// File: hw/rtl/wts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wts_queue
// Shifting queue of task ids: append, insert at position, drop head, remove id.
// ----------------------------------------------------------------------------
module wts_queue #(
    parameter int DEPTH = 16,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wts_pkg::wts_q_op_t op,
    input  wire logic [IW-1:0]      key,
    input  wire logic [CW-1:0]      pos,
    output logic      [CW-1:0]      count,
    output logic      [IW-1:0]      head,
    output logic      [IW-1:0]      at_pos
);
    import wts_pkg::*;

    logic [IW-1:0] ids_reg  [DEPTH];
    logic [IW-1:0] ids_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          found;
    logic [CW-1:0] mpos;
    logic          not_full;

    assign not_full = count_reg < CW'(DEPTH);
    assign count    = count_reg;
    assign head     = ids_reg[0];

    // first entry holding key
    always_comb
    begin
        found = 1'b0;
        mpos  = '0;
        for (int j = DEPTH - 1; j >= 0; j--)
        begin
            if (CW'(j) < count_reg && ids_reg[j] == key)
            begin
                found = 1'b1;
                mpos  = CW'(j);
            end
        end
    end

    always_comb
    begin
        at_pos = ids_reg[0];
        for (int j = 0; j < DEPTH; j++)
        begin
            if (CW'(j) == pos)
            begin
                at_pos = ids_reg[j];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int j = 0; j < DEPTH; j++)
        begin
            ids_next[j] = ids_reg[j];
            case (op)
                Q_APPEND:
                begin
                    if (CW'(j) == count_reg)
                    begin
                        ids_next[j] = key;
                    end
                end
                Q_INSERT:
                begin
                    if (not_full)
                    begin
                        if (CW'(j) == pos)
                        begin
                            ids_next[j] = key;
                        end
                        else if (CW'(j) > pos)
                        begin
                            ids_next[j] = ids_reg[(j == 0) ? 0 : j - 1];
                        end
                    end
                end
                Q_DROP:
                begin
                    ids_next[j] = ids_reg[(j < DEPTH - 1) ? j + 1 : j];
                end
                Q_REMOVE:
                begin
                    if (found && CW'(j) >= mpos)
                    begin
                        ids_next[j] = ids_reg[(j < DEPTH - 1) ? j + 1 : j];
                    end
                end
                default:
                begin
                    ids_next[j] = ids_reg[j];
                end
            endcase
        end
        case (op)
            Q_APPEND, Q_INSERT:
            begin
                if (not_full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            Q_DROP:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            Q_REMOVE:
            begin
                if (found)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ids_reg <= ids_next;
    end

endmodule
`default_nettype wire

// File: hw/rtl/wts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wts_datapath
// Request latch, wake-time memory, booked flags, the three queues and results.
// ----------------------------------------------------------------------------
module wts_datapath #(
    parameter int TASKS = 16,
    localparam int IW = $clog2(TASKS),
    localparam int CW = $clog2(TASKS + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire wts_pkg::wts_cmd_t                 cmd,
    output wts_pkg::wts_status_t                   status,
    input  wire logic [wts_pkg::OP_W-1:0]          opcode,
    input  wire logic [wts_pkg::ID_W-1:0]          task_id,
    input  wire logic [wts_pkg::MODE_W-1:0]        wake_mode,
    input  wire logic [wts_pkg::TIME_W-1:0]        wake_value,
    input  wire logic [wts_pkg::TIME_W-1:0]        now_ticks,
    input  wire logic [wts_pkg::TIME_W-1:0]        now_ms,
    input  wire logic                              cfg_we,
    input  wire logic [wts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wts_pkg::CFG_DAT_W-1:0]     cfg_data,
    output logic      [wts_pkg::OUT_W-1:0]         outcome,
    output logic      [wts_pkg::ID_W-1:0]          dispatched_task,
    output logic                                   went_ready,
    output logic                                   wrap_error
);
    import wts_pkg::*;

    // latched request
    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [TIME_W-1:0]   val_reg;
    logic [TIME_W-1:0]   nowt_reg;
    logic [TIME_W-1:0]   nowm_reg;

    logic [TPM_W-1:0]    tpm_reg;
    logic [MARGIN_W-1:0] margin_reg;

    logic [TIME_W-1:0]   wake_mem [TASKS];
    logic [TIME_W-1:0]   rd_reg;
    logic [TIME_W-1:0]   wnew_reg;
    logic [TIME_W-1:0]   delay_reg;
    logic [TASKS-1:0]    booked_reg;
    logic [CW-1:0]       pos_reg;
    logic                tgt_msec_reg;

    logic [OUT_W-1:0]    wout_reg;
    logic [ID_W-1:0]     wdisp_reg;
    logic                went_reg;
    logic                wrap_reg;
    logic [OUT_W-1:0]    out_outcome_reg;
    logic [ID_W-1:0]     out_disp_reg;
    logic                out_went_reg;
    logic                out_wrap_reg;

    logic                id_ok;
    logic [IW-1:0]       id_idx;
    logic                is_msec;
    logic                is_rel;
    logic [TIME_W-1:0]   now_sel;
    logic [TIME_W-1:0]   wake_calc;
    logic [TIME_W-1:0]   ofs;
    logic                ofs_pos;
    logic [TIME_W-1:0]   tick_delay;
    logic                busy;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;

    wts_q_op_t           tick_op;
    wts_q_op_t           msec_op;
    wts_q_op_t           rdy_op;
    logic [IW-1:0]       rdy_key;
    logic [CW-1:0]       tick_count;
    logic [CW-1:0]       msec_count;
    logic [CW-1:0]       rdy_count;
    logic [IW-1:0]       tick_head;
    logic [IW-1:0]       msec_head;
    logic [IW-1:0]       rdy_head;
    logic [IW-1:0]       tick_at;
    logic [IW-1:0]       msec_at;
    logic [IW-1:0]       rdy_at;
    logic [CW-1:0]       tgt_count;
    logic [IW-1:0]       tgt_at;

    assign id_ok   = 32'(id_reg) < 32'(TASKS);
    assign id_idx  = IW'(id_reg);
    assign is_msec = mode_reg[0];
    assign is_rel  = mode_reg[1];
    assign now_sel = is_msec ? nowm_reg : nowt_reg;

    assign wake_calc = is_rel ? now_sel + val_reg : val_reg;
    assign ofs       = is_rel ? val_reg
                              : val_reg - now_sel - (is_msec ? '0 : TIME_W'(margin_reg));
    assign ofs_pos   = $signed(ofs) > 32'sd0;

    assign tick_delay = rd_reg - nowt_reg;
    assign busy       = (tick_count != '0) && ($signed(delay_reg) < $signed(TIME_W'(tpm_reg)));

    assign tgt_count = tgt_msec_reg ? msec_count : tick_count;
    assign tgt_at    = tgt_msec_reg ? msec_at : tick_at;

    always_comb
    begin
        status.is_queue   = (op_reg == OP_QUEUE) && id_ok;
        status.is_cancel  = (op_reg == OP_CANCEL) && id_ok;
        status.is_run     = op_reg == OP_RUN;
        status.booked     = booked_reg[id_idx];
        status.ofs_pos    = ofs_pos;
        status.ins_end    = pos_reg == tgt_count;
        status.ins_later  = $signed(wnew_reg - rd_reg) > 32'sd0;
        status.tick_empty = tick_count == '0;
        status.tick_due   = $signed(tick_delay) < $signed(TIME_W'(margin_reg));
        status.msec_empty = msec_count == '0;
        status.msec_due   = $signed(rd_reg - nowm_reg) <= 32'sd0;
    end

    // queue commands
    always_comb
    begin
        tick_op = Q_NOP;
        msec_op = Q_NOP;
        rdy_op  = Q_NOP;
        rdy_key = id_idx;
        if (cmd.cancel)
        begin
            tick_op = Q_REMOVE;
            msec_op = Q_REMOVE;
            rdy_op  = Q_REMOVE;
        end
        if (cmd.ins_do)
        begin
            if (tgt_msec_reg)
            begin
                msec_op = Q_INSERT;
            end
            else
            begin
                tick_op = Q_INSERT;
            end
        end
        if (cmd.set_wake && !ofs_pos)
        begin
            rdy_op = Q_APPEND;
        end
        if (cmd.tick_pop)
        begin
            tick_op = Q_DROP;
            rdy_op  = Q_APPEND;
            rdy_key = tick_head;
        end
        if (cmd.msec_pop)
        begin
            msec_op = Q_DROP;
            rdy_op  = Q_APPEND;
            rdy_key = msec_head;
        end
        if (cmd.run_end && rdy_count != '0)
        begin
            rdy_op = Q_DROP;
        end
    end

    wts_queue #(.DEPTH(TASKS)) u_tick_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (tick_op),
        .key    (id_idx),
        .pos    (pos_reg),
        .count  (tick_count),
        .head   (tick_head),
        .at_pos (tick_at)
    );

    wts_queue #(.DEPTH(TASKS)) u_msec_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (msec_op),
        .key    (id_idx),
        .pos    (pos_reg),
        .count  (msec_count),
        .head   (msec_head),
        .at_pos (msec_at)
    );

    wts_queue #(.DEPTH(TASKS)) u_rdy_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (rdy_op),
        .key    (rdy_key),
        .pos    (pos_reg),
        .count  (rdy_count),
        .head   (rdy_head),
        .at_pos (rdy_at)
    );

    // wake-time memory: one write, one registered read
    assign rd_en   = cmd.ins_rd || cmd.tick_rd || cmd.msec_rd;
    assign rd_addr = cmd.ins_rd ? tgt_at : (cmd.tick_rd ? tick_head : msec_head);

    always_ff @(posedge clk)
    begin
        if (cmd.set_wake)
        begin
            wake_mem[id_idx] <= wake_calc;
        end
        if (rd_en)
        begin
            rd_reg <= wake_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            booked_reg <= '0;
            tpm_reg    <= TPM_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_TPM)
            begin
                tpm_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_MARGIN)
            begin
                margin_reg <= cfg_data[MARGIN_W-1:0];
            end
            if (cmd.cancel)
            begin
                booked_reg[id_idx] <= 1'b0;
            end
            if (cmd.set_wake)
            begin
                booked_reg[id_idx] <= 1'b1;
            end
            if (cmd.run_end && rdy_count != '0)
            begin
                booked_reg[rdy_head] <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= opcode;
            id_reg    <= task_id;
            mode_reg  <= wake_mode;
            val_reg   <= wake_value;
            nowt_reg  <= now_ticks;
            nowm_reg  <= now_ms;
            delay_reg <= TIME_W'(tpm_reg);
            wout_reg  <= OUT_DONE;
            wdisp_reg <= '0;
            went_reg  <= 1'b0;
            wrap_reg  <= 1'b0;
        end
        if (cmd.set_wake)
        begin
            wnew_reg     <= wake_calc;
            tgt_msec_reg <= is_msec;
            pos_reg      <= '0;
            if (!ofs_pos)
            begin
                went_reg <= 1'b1;
                wrap_reg <= $signed(ofs) < WRAP_LIMIT;
            end
        end
        if (cmd.ins_step)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.tick_cmp)
        begin
            delay_reg <= tick_delay;
        end
        if (cmd.run_end)
        begin
            if (rdy_count != '0)
            begin
                wout_reg  <= OUT_DISPATCH;
                wdisp_reg <= ID_W'(rdy_head);
            end
            else if (busy)
            begin
                wout_reg <= OUT_BUSY;
            end
            else
            begin
                wout_reg <= OUT_SLEEP;
            end
        end
        if (cmd.load_out)
        begin
            out_outcome_reg <= wout_reg;
            out_disp_reg    <= wdisp_reg;
            out_went_reg    <= went_reg;
            out_wrap_reg    <= wrap_reg;
        end
    end

    assign outcome         = out_outcome_reg;
    assign dispatched_task = out_disp_reg;
    assign went_ready      = out_went_reg;
    assign wrap_error      = out_wrap_reg;

endmodule
`default_nettype wire

// File: hw/rtl/wts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wts_ctrl
// Request sequencer: steps the datapath through queue, cancel and run.
// ----------------------------------------------------------------------------
module wts_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire wts_pkg::wts_status_t  status,
    output wts_pkg::wts_cmd_t          cmd
);
    import wts_pkg::*;

    wts_state_t state_reg;
    wts_state_t state_next;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_queue)
                begin
                    state_next = status.booked ? ST_CANCEL : ST_SET;
                end
                else if (status.is_cancel)
                begin
                    state_next = ST_CANCEL;
                end
                else if (status.is_run)
                begin
                    state_next = ST_TICK_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CANCEL:   state_next = status.is_queue ? ST_SET : ST_DONE;
            ST_SET:      state_next = status.ofs_pos ? ST_INS_RD : ST_DONE;
            ST_INS_RD:   state_next = status.ins_end ? ST_DONE : ST_INS_CMP;
            ST_INS_CMP:  state_next = status.ins_later ? ST_INS_RD : ST_DONE;
            ST_TICK_RD:  state_next = status.tick_empty ? ST_MSEC_RD : ST_TICK_CMP;
            ST_TICK_CMP: state_next = status.tick_due ? ST_TICK_RD : ST_MSEC_RD;
            ST_MSEC_RD:  state_next = status.msec_empty ? ST_RUN_END : ST_MSEC_CMP;
            ST_MSEC_CMP: state_next = status.msec_due ? ST_MSEC_RD : ST_RUN_END;
            ST_RUN_END:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ST_CANCEL:  cmd.cancel   = 1'b1;
            ST_SET:     cmd.set_wake = 1'b1;
            ST_INS_RD:
            begin
                cmd.ins_do = status.ins_end;
                cmd.ins_rd = !status.ins_end;
            end
            ST_INS_CMP:
            begin
                cmd.ins_step = status.ins_later;
                cmd.ins_do   = !status.ins_later;
            end
            ST_TICK_RD: cmd.tick_rd = !status.tick_empty;
            ST_TICK_CMP:
            begin
                cmd.tick_cmp = 1'b1;
                cmd.tick_pop = status.tick_due;
            end
            ST_MSEC_RD:  cmd.msec_rd  = !status.msec_empty;
            ST_MSEC_CMP: cmd.msec_pop = status.msec_due;
            ST_RUN_END:  cmd.run_end  = 1'b1;
            ST_DONE:     cmd.load_out = out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted word not decoded");

    a_tick_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_pop |-> !status.tick_empty)
        else $error("pop from empty tick queue");

    a_done_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result not presented");

endmodule
`default_nettype wire
